[src/blkavg_pkg.sv]
package blkavg_pkg;

    localparam int PIX_W        = 8;
    localparam int NUM_CH       = 3;
    localparam int QUO_W        = 8;
    localparam int SCALE_W      = 5;
    localparam int DIM_W        = 12;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;
    localparam int FIFO_D       = 16;
    localparam int PTR_W        = $clog2(FIFO_D);
    localparam int CNT_W        = $clog2(FIFO_D + 1);

    localparam logic [SCALE_W-1:0] RST_SCALE  = SCALE_W'(2);
    localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(480);
    localparam logic               RST_COLOUR = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_COLOUR
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic add;
        logic done;
        logic first;
        logic clear;
    } t_lane_ctl;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } t_tag;

    typedef struct packed {
        t_pix avg_c0;
        t_pix avg_c1;
        t_pix avg_c2;
        logic row_end;
        logic frame_end;
    } t_res;

endpackage

[src/blkavg_ifs.sv]
interface blkavg_pix_if;
    logic                 valid;
    logic                 ready;
    blkavg_pkg::t_pix     pix_c0;
    blkavg_pkg::t_pix     pix_c1;
    blkavg_pkg::t_pix     pix_c2;

    modport source (output valid, output pix_c0, output pix_c1, output pix_c2, input ready);
    modport sink   (input valid, input pix_c0, input pix_c1, input pix_c2, output ready);
endinterface

interface blkavg_res_if;
    logic                 valid;
    logic                 ready;
    blkavg_pkg::t_pix     avg_c0;
    blkavg_pkg::t_pix     avg_c1;
    blkavg_pkg::t_pix     avg_c2;
    logic                 row_end;
    logic                 frame_end;

    modport source (output valid, output avg_c0, output avg_c1, output avg_c2,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input avg_c0, input avg_c1, input avg_c2,
                    input row_end, input frame_end, output ready);
endinterface

interface blkavg_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [blkavg_pkg::CFG_IDX_W-1:0]       index;
    logic [blkavg_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/blkavg_ctrl.sv]
module blkavg_ctrl #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    blkavg_pix_if.sink                                  i_pix,
    blkavg_cfg_if.sink                                  i_cfg,
    input  logic                                        i_credit,
    output blkavg_pkg::t_lane_ctl                       o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]                o_col,
    output blkavg_pkg::t_pix [blkavg_pkg::NUM_CH-1:0]   o_pix,
    output logic [2*$clog2(((MAX_SCALE < (2**blkavg_pkg::SCALE_W) - 1) ? MAX_SCALE :
                            (2**blkavg_pkg::SCALE_W) - 1) + 1)-1:0] o_area,
    output blkavg_pkg::t_tag                            o_tag
);

    localparam int SMAX   = (MAX_SCALE < (2**blkavg_pkg::SCALE_W) - 1) ? MAX_SCALE :
                            (2**blkavg_pkg::SCALE_W) - 1;
    localparam int SCW    = $clog2(SMAX + 1);
    localparam int AREA_W = 2 * SCW;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int XW     = $clog2(MAX_WIDTH + SMAX + 1);
    localparam int DW     = blkavg_pkg::DIM_W;
    localparam int RW     = $clog2(blkavg_pkg::HEIGHT_LIMIT);

    logic [blkavg_pkg::SCALE_W-1:0] r_scale;
    logic [DW-1:0]                  r_width;
    logic [DW-1:0]                  r_height;
    logic                           r_colour;
    logic [AREA_W-1:0]              r_area;

    logic [CW-1:0]  r_in_col;
    logic [WW-1:0]  r_col_base;
    logic [WW-1:0]  r_out_col;
    logic [SCW-1:0] r_sub_col;
    logic [RW-1:0]  r_in_row;
    logic [DW-1:0]  r_row_base;
    logic [SCW-1:0] r_sub_row;

    logic [SCW-1:0] s_eff;
    logic [WW-1:0]  w_eff;
    logic [DW-1:0]  h_eff;
    logic           cfg_wr;
    logic           cfg_hit;
    logic           acc;
    logic           row_act;
    logic           col_act;
    logic           sub_last;
    logic           sub_row_last;
    logic           row_end;
    logic           frame_last;
    logic           rend_flag;
    logic           fend_flag;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = i_credit;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign acc         = i_pix.valid && i_pix.ready;

    always_comb begin
        cfg_hit = 1'b0;
        unique case (i_cfg.index) inside
            blkavg_pkg::CFG_SCALE, blkavg_pkg::CFG_WIDTH,
            blkavg_pkg::CFG_HEIGHT, blkavg_pkg::CFG_COLOUR: cfg_hit = cfg_wr;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (r_scale == '0) begin
            s_eff = SCW'(1);
        end else if (int'(r_scale) > MAX_SCALE) begin
            s_eff = SCW'(MAX_SCALE);
        end else begin
            s_eff = SCW'(r_scale);
        end
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = DW'(1);
        end else if (int'(r_height) > blkavg_pkg::HEIGHT_LIMIT) begin
            h_eff = DW'(blkavg_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end
    end

    always_comb begin
        row_act      = ((DW+1)'(r_row_base) + (DW+1)'(s_eff)) <= (DW+1)'(h_eff);
        col_act      = row_act && ((XW'(r_col_base) + XW'(s_eff)) <= XW'(w_eff));
        sub_last     = ((SCW+1)'(r_sub_col) + (SCW+1)'(1)) >= (SCW+1)'(s_eff);
        sub_row_last = ((SCW+1)'(r_sub_row) + (SCW+1)'(1)) >= (SCW+1)'(s_eff);
        row_end      = (WW'(r_in_col) + WW'(1)) >= w_eff;
        frame_last   = (DW'(r_in_row) + DW'(1)) >= h_eff;
        rend_flag    = (XW'(r_in_col) + XW'(1) + XW'(s_eff)) > XW'(w_eff);
        fend_flag    = rend_flag &&
                       (((DW+1)'(r_in_row) + (DW+1)'(1) + (DW+1)'(s_eff)) > (DW+1)'(h_eff));
    end

    always_comb begin
        o_ctl.add       = acc && col_act;
        o_ctl.done      = acc && col_act && sub_last;
        o_ctl.first     = (r_sub_row == '0);
        o_ctl.clear     = cfg_hit || (acc && row_end);
        o_tag.emit      = acc && col_act && sub_last && sub_row_last;
        o_tag.row_end   = rend_flag;
        o_tag.frame_end = fend_flag;
        o_col           = r_out_col[CW-1:0];
        o_area          = r_area;
        o_pix[0]        = i_pix.pix_c0;
        o_pix[1]        = r_colour ? i_pix.pix_c1 : '0;
        o_pix[2]        = r_colour ? i_pix.pix_c2 : '0;
    end

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(s_eff) * AREA_W'(s_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= blkavg_pkg::RST_SCALE;
            r_width  <= blkavg_pkg::RST_WIDTH;
            r_height <= blkavg_pkg::RST_HEIGHT;
            r_colour <= blkavg_pkg::RST_COLOUR;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                blkavg_pkg::CFG_SCALE:  r_scale  <= i_cfg.data[blkavg_pkg::SCALE_W-1:0];
                blkavg_pkg::CFG_WIDTH:  r_width  <= i_cfg.data[DW-1:0];
                blkavg_pkg::CFG_HEIGHT: r_height <= i_cfg.data[DW-1:0];
                blkavg_pkg::CFG_COLOUR: r_colour <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col   <= '0;
            r_col_base <= '0;
            r_out_col  <= '0;
            r_sub_col  <= '0;
            r_in_row   <= '0;
            r_row_base <= '0;
            r_sub_row  <= '0;
        end else if (acc) begin
            if (col_act) begin
                if (sub_last) begin
                    r_sub_col  <= '0;
                    r_col_base <= WW'(r_in_col) + WW'(1);
                    r_out_col  <= r_out_col + WW'(1);
                end else begin
                    r_sub_col <= r_sub_col + SCW'(1);
                end
            end
            if (row_end) begin
                r_in_col   <= '0;
                r_col_base <= '0;
                r_out_col  <= '0;
                r_sub_col  <= '0;
                if (frame_last) begin
                    r_in_row   <= '0;
                    r_row_base <= '0;
                    r_sub_row  <= '0;
                end else begin
                    r_in_row <= r_in_row + RW'(1);
                    if (row_act) begin
                        if (sub_row_last) begin
                            r_sub_row  <= '0;
                            r_row_base <= DW'(r_in_row) + DW'(1);
                        end else begin
                            r_sub_row <= r_sub_row + SCW'(1);
                        end
                    end
                end
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end
    end

endmodule

[src/blkavg_lane.sv]
module blkavg_lane #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  blkavg_pkg::t_lane_ctl             i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_col,
    input  blkavg_pkg::t_pix                  i_pix,
    input  logic [2*$clog2(((MAX_SCALE < (2**blkavg_pkg::SCALE_W) - 1) ? MAX_SCALE :
                            (2**blkavg_pkg::SCALE_W) - 1) + 1)-1:0] i_area,
    output blkavg_pkg::t_pix                  o_avg
);

    localparam int SMAX   = (MAX_SCALE < (2**blkavg_pkg::SCALE_W) - 1) ? MAX_SCALE :
                            (2**blkavg_pkg::SCALE_W) - 1;
    localparam int SCW    = $clog2(SMAX + 1);
    localparam int AREA_W = 2 * SCW;
    localparam int SUM_W  = blkavg_pkg::PIX_W + AREA_W;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int QW     = blkavg_pkg::QUO_W;

    logic [SUM_W-1:0] r_col_mem [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd;
    logic [SUM_W-1:0] r_run;
    logic [SUM_W-1:0] r_b_run;
    logic [CW-1:0]    r_b_col;
    logic             r_b_first;
    logic             r_b_valid;
    logic [SUM_W-1:0] w_sum;

    logic [SUM_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [SUM_W-1:0] rem_in [QW];
    logic [QW-1:0]    q_in   [QW];
    logic [SUM_W-1:0] trial  [QW];
    logic [SUM_W-1:0] n_rem  [QW];
    logic [QW-1:0]    n_q    [QW];

    assign w_sum = r_b_first ? r_b_run : (r_rd + r_b_run);
    assign o_avg = r_q[QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear || i_ctl.done) begin
            r_run <= '0;
        end else if (i_ctl.add) begin
            r_run <= r_run + SUM_W'(i_pix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_ctl.done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_run   <= r_run + SUM_W'(i_pix);
        r_b_col   <= i_col;
        r_b_first <= i_ctl.first;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.done) begin
            r_rd <= r_col_mem[i_col];
        end
        if (r_b_valid) begin
            r_col_mem[r_b_col] <= w_sum;
        end
    end

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem_in[k] = w_sum;
                q_in[k]   = '0;
            end else begin
                rem_in[k] = r_rem[k-1];
                q_in[k]   = r_q[k-1];
            end
            trial[k] = SUM_W'(i_area) << (QW - 1 - k);
            n_rem[k] = rem_in[k];
            n_q[k]   = q_in[k];
            if (rem_in[k] >= trial[k]) begin
                n_rem[k]         = rem_in[k] - trial[k];
                n_q[k][QW-1-k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
        end
    end

endmodule

[src/blkavg_merge.sv]
module blkavg_merge (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  blkavg_pkg::t_tag                            i_tag,
    input  blkavg_pkg::t_pix [blkavg_pkg::NUM_CH-1:0]   i_avg,
    blkavg_res_if.source                                o_res,
    output logic                                        o_credit
);

    localparam int DLY = blkavg_pkg::QUO_W + 1;

    blkavg_pkg::t_tag                   r_dly [DLY];
    blkavg_pkg::t_res                   r_fifo [blkavg_pkg::FIFO_D];
    logic [blkavg_pkg::PTR_W-1:0]       r_wr_ptr;
    logic [blkavg_pkg::PTR_W-1:0]       r_rd_ptr;
    logic [blkavg_pkg::CNT_W-1:0]       r_fill;
    logic [blkavg_pkg::CNT_W-1:0]       r_cnt;
    blkavg_pkg::t_res                   push_item;
    blkavg_pkg::t_res                   head;
    logic                               push;
    logic                               pop;

    assign push     = r_dly[DLY-1].emit;
    assign pop      = o_res.valid && o_res.ready;
    assign o_credit = r_cnt < blkavg_pkg::CNT_W'(blkavg_pkg::FIFO_D);
    assign head     = r_fifo[r_rd_ptr];

    always_comb begin
        push_item.avg_c0    = i_avg[0];
        push_item.avg_c1    = i_avg[1];
        push_item.avg_c2    = i_avg[2];
        push_item.row_end   = r_dly[DLY-1].row_end;
        push_item.frame_end = r_dly[DLY-1].frame_end;
        o_res.valid         = (r_fill != '0);
        o_res.avg_c0        = head.avg_c0;
        o_res.avg_c1        = head.avg_c1;
        o_res.avg_c2        = head.avg_c2;
        o_res.row_end       = head.row_end;
        o_res.frame_end     = head.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) begin
                r_dly[k] <= '0;
            end
        end else begin
            r_dly[0] <= i_tag;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + blkavg_pkg::PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + blkavg_pkg::PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + blkavg_pkg::CNT_W'(1);
                2'b01:   r_fill <= r_fill - blkavg_pkg::CNT_W'(1);
                default: r_fill <= r_fill;
            endcase
            case ({i_tag.emit, pop})
                2'b10:   r_cnt <= r_cnt + blkavg_pkg::CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - blkavg_pkg::CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/block_average_downscaler.sv]
// block averaging downscaler, one pixel transfer per cycle while the output queue has room
// a result passes the store read-modify-write stage and eight divider stages,
// then is written into the queue
// input ready drops only when 16 results are in flight, set by the output queue depth
// reset (i_rst_n low, synchronous) restores default registers, clears counters and queue
// the column store is not cleared; each column is written before its stored value is used
module block_average_downscaler #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    blkavg_cfg_if.sink   i_cfg,
    blkavg_pix_if.sink   i_pix,
    blkavg_res_if.source o_res
);

    localparam int SMAX   = (MAX_SCALE < (2**blkavg_pkg::SCALE_W) - 1) ? MAX_SCALE :
                            (2**blkavg_pkg::SCALE_W) - 1;
    localparam int AREA_W = 2 * $clog2(SMAX + 1);
    localparam int CW     = $clog2(MAX_WIDTH);

    blkavg_pkg::t_lane_ctl                      ctl;
    blkavg_pkg::t_tag                           tag;
    blkavg_pkg::t_pix [blkavg_pkg::NUM_CH-1:0]  pix;
    blkavg_pkg::t_pix [blkavg_pkg::NUM_CH-1:0]  avg;
    logic [CW-1:0]                              col;
    logic [AREA_W-1:0]                          area;
    logic                                       credit;

    blkavg_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_credit (credit),
        .o_ctl    (ctl),
        .o_col    (col),
        .o_pix    (pix),
        .o_area   (area),
        .o_tag    (tag)
    );

    for (genvar g = 0; g < blkavg_pkg::NUM_CH; g++) begin : g_lane
        blkavg_lane #(
            .MAX_WIDTH (MAX_WIDTH),
            .MAX_SCALE (MAX_SCALE)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_col   (col),
            .i_pix   (pix[g]),
            .i_area  (area),
            .o_avg   (avg[g])
        );
    end

    blkavg_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_avg    (avg),
        .o_res    (o_res),
        .o_credit (credit)
    );

endmodule

[src/blkavg_chk.sv]
module blkavg_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_cfg_valid,
    input logic                                 i_cfg_ready,
    input logic [blkavg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [blkavg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input logic                                 i_res_valid,
    input logic                                 i_res_ready,
    input blkavg_pkg::t_pix                     i_avg_c0,
    input blkavg_pkg::t_pix                     i_avg_c1,
    input blkavg_pkg::t_pix                     i_avg_c2,
    input logic                                 i_row_end,
    input logic                                 i_frame_end
);

    logic r_colour;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= blkavg_pkg::RST_COLOUR;
        end else if (i_cfg_valid && i_cfg_ready && (i_cfg_index == blkavg_pkg::CFG_COLOUR)) begin
            r_colour <= i_cfg_data[0];
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid &&
        $stable({i_avg_c0, i_avg_c1, i_avg_c2, i_row_end, i_frame_end}))
        else $error("stalled result changed");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_frame_end |-> i_row_end)
        else $error("frame end without row end");

    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !r_colour |-> (i_avg_c1 == '0) && (i_avg_c2 == '0))
        else $error("grey mode result with nonzero colour channels");

endmodule

bind block_average_downscaler blkavg_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_avg_c0    (o_res.avg_c0),
    .i_avg_c1    (o_res.avg_c1),
    .i_avg_c2    (o_res.avg_c2),
    .i_row_end   (o_res.row_end),
    .i_frame_end (o_res.frame_end)
);

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCALE_CAP = 16;
    localparam int unsigned WIDTH_CAP = 2048;
    localparam int unsigned SETTLE    = 24;
    localparam int unsigned LIMIT     = 600000;

    class block_mean_tracker;
        logic [blkavg_pkg::SCALE_W-1:0] scale_reg;
        logic [blkavg_pkg::DIM_W-1:0]   width_reg;
        logic [blkavg_pkg::DIM_W-1:0]   height_reg;
        logic                           colour_reg;

        int unsigned line_store [WIDTH_CAP][blkavg_pkg::NUM_CH];
        int unsigned strip_acc [blkavg_pkg::NUM_CH];
        int unsigned x_pos, y_pos, x_phase, y_phase, block_col;

        blkavg_pkg::t_res pending_means [$];
        int unsigned errors;

        function new();
            scale_reg  = blkavg_pkg::RST_SCALE;
            width_reg  = blkavg_pkg::RST_WIDTH;
            height_reg = blkavg_pkg::RST_HEIGHT;
            colour_reg = blkavg_pkg::RST_COLOUR;
            foreach (line_store[i, k]) line_store[i][k] = 0;
            restart();
        endfunction

        function void restart();
            foreach (strip_acc[k]) strip_acc[k] = 0;
            x_pos = 0;
            y_pos = 0;
            x_phase = 0;
            y_phase = 0;
            block_col = 0;
        endfunction

        function int unsigned limit_to(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void apply_reg(logic [blkavg_pkg::CFG_IDX_W-1:0] idx,
                                logic [blkavg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                blkavg_pkg::CFG_SCALE:  scale_reg  = data[blkavg_pkg::SCALE_W-1:0];
                blkavg_pkg::CFG_WIDTH:  width_reg  = data[blkavg_pkg::DIM_W-1:0];
                blkavg_pkg::CFG_HEIGHT: height_reg = data[blkavg_pkg::DIM_W-1:0];
                blkavg_pkg::CFG_COLOUR: colour_reg = data[0];
                default:                return;
            endcase
            restart();
        endfunction

        // one accepted pixel; queues a block mean when it closes a block
        function void take_pixel(blkavg_pkg::t_pix c0, blkavg_pkg::t_pix c1,
                                 blkavg_pkg::t_pix c2);
            int unsigned s, w, h, out_cols, out_rows, col, area;
            int unsigned px [blkavg_pkg::NUM_CH];
            bit row_active;
            blkavg_pkg::t_res mean;
            s = limit_to(scale_reg, SCALE_CAP);
            w = limit_to(width_reg, WIDTH_CAP);
            h = limit_to(height_reg, blkavg_pkg::HEIGHT_LIMIT);
            out_cols = w / s;
            out_rows = h / s;
            row_active = y_pos < out_rows * s;
            px[0] = c0;
            px[1] = colour_reg ? c1 : 0;
            px[2] = colour_reg ? c2 : 0;

            if (row_active && x_pos < out_cols * s) begin
                foreach (strip_acc[k]) strip_acc[k] += px[k];
                x_phase++;
                if (x_phase >= s) begin
                    col = block_col % WIDTH_CAP;
                    x_phase = 0;
                    foreach (strip_acc[k]) begin
                        if (y_phase == 0) line_store[col][k] = strip_acc[k];
                        else line_store[col][k] += strip_acc[k];
                        strip_acc[k] = 0;
                    end
                    if (y_phase + 1 >= s) begin
                        area = s * s;
                        mean.avg_c0 = blkavg_pkg::t_pix'(line_store[col][0] / area);
                        mean.avg_c1 = blkavg_pkg::t_pix'(line_store[col][1] / area);
                        mean.avg_c2 = blkavg_pkg::t_pix'(line_store[col][2] / area);
                        mean.row_end = (block_col + 1 == out_cols);
                        mean.frame_end = mean.row_end && (y_pos + 1 == out_rows * s);
                        pending_means.insert(pending_means.size(), mean);
                    end
                    block_col++;
                end
            end

            x_pos++;
            if (x_pos >= w) begin
                x_pos = 0;
                block_col = 0;
                x_phase = 0;
                foreach (strip_acc[k]) strip_acc[k] = 0;
                if (row_active) begin
                    y_phase++;
                    if (y_phase >= s) y_phase = 0;
                end
                y_pos++;
                if (y_pos >= h) begin
                    y_pos = 0;
                    y_phase = 0;
                end
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_mean(blkavg_pkg::t_res got);
            blkavg_pkg::t_res want;
            if (pending_means.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d re=%0b fe=%0b",
                         $time, got.avg_c0, got.avg_c1, got.avg_c2, got.row_end,
                         got.frame_end);
                return;
            end
            want = pending_means.pop_front();
            compare_field("avg_c0", want.avg_c0, got.avg_c0);
            compare_field("avg_c1", want.avg_c1, got.avg_c1);
            compare_field("avg_c2", want.avg_c2, got.avg_c2);
            compare_field("row_end", want.row_end, got.row_end);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    blkavg_cfg_if cfg();
    blkavg_pix_if pix();
    blkavg_res_if res();

    block_average_downscaler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (pix),
        .o_res   (res)
    );

    block_mean_tracker tracker = new();
    bit steady_flow;
    int unsigned hold_left;
    int unsigned cycles;
    int unsigned sent;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic blkavg_pkg::t_pix pick_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return blkavg_pkg::t_pix'($urandom_range(255));
        endcase
    endfunction

    task automatic push_pixel(blkavg_pkg::t_pix c0, blkavg_pkg::t_pix c1,
                              blkavg_pkg::t_pix c2);
        while (!steady_flow && $urandom_range(99) < 37) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid  <= 1'b1;
        pix.pix_c0 <= c0;
        pix.pix_c1 <= c1;
        pix.pix_c2 <= c2;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        tracker.take_pixel(c0, c1, c2);
        sent++;
    endtask

    task automatic stream_pixels(int unsigned count);
        repeat (count) push_pixel(pick_level(), pick_level(), pick_level());
    endtask

    // waits until no block mean is outstanding and the pipeline has drained
    task automatic drain();
        pix.valid <= 1'b0;
        while (tracker.pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [blkavg_pkg::CFG_IDX_W-1:0] idx,
                             logic [blkavg_pkg::CFG_DATA_W-1:0] data);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        tracker.apply_reg(idx, data);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_geometry(logic [blkavg_pkg::CFG_DATA_W-1:0] scale,
                                logic [blkavg_pkg::CFG_DATA_W-1:0] width,
                                logic [blkavg_pkg::CFG_DATA_W-1:0] height,
                                logic [blkavg_pkg::CFG_DATA_W-1:0] colour);
        write_reg(blkavg_pkg::CFG_SCALE, scale);
        write_reg(blkavg_pkg::CFG_WIDTH, width);
        write_reg(blkavg_pkg::CFG_HEIGHT, height);
        write_reg(blkavg_pkg::CFG_COLOUR, colour);
    endtask

    // result side: checks each transfer, then picks ready for the next edge
    initial begin
        blkavg_pkg::t_res got;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                got.avg_c0    = res.avg_c0;
                got.avg_c1    = res.avg_c1;
                got.avg_c2    = res.avg_c2;
                got.row_end   = res.row_end;
                got.frame_end = res.frame_end;
                tracker.check_mean(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= steady_flow || ($urandom_range(99) >= 37);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("block_average_downscaler regression: fail");
        $finish;
    end

    initial begin
        int unsigned sc, w, h, s_eff, w_eff, h_eff, frame, n;
        logic [blkavg_pkg::CFG_DATA_W-1:0] scale_data, colour_data;

        i_rst_n     = 1'b0;
        steady_flow = 1'b0;
        hold_left   = 0;
        sent        = 0;
        pix.valid   = 1'b0;
        pix.pix_c0  = '0;
        pix.pix_c1  = '0;
        pix.pix_c2  = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // colour, full-scale and truncating blocks, trailing column and row
        set_geometry(2, 5, 3, 1);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (r < 2 && c < 2)
                    push_pixel(8'hFF, 8'hFF, 8'hFF);
                else if (r < 2 && c < 4)
                    push_pixel((r == 0 && c == 2) ? 8'd1 : 8'd0,
                               (r == 1 && c == 3) ? 8'd254 : 8'd255, 8'd7);
                else
                    push_pixel(pick_level(), pick_level(), pick_level());
            end
        end

        // scale zero acts as one, grey mode drops channels one and two
        set_geometry(0, 3, 1, 0);
        repeat (3) push_pixel(pick_level(), 8'hFF, 8'hA5);

        // block larger than the image gives nothing
        set_geometry(3, 2, 2, 1);
        stream_pixels(4);

        // scale above the cap
        set_geometry(31, 17, 16, 1);
        stream_pixels(272);

        // receiver stalls for a long stretch while pixels keep coming
        set_geometry(1, 16, 8, 1);
        steady_flow = 1'b1;
        hold_left   = 300;
        stream_pixels(128);
        drain();
        steady_flow = 1'b0;

        while (sent < 1300) begin
            case ($urandom_range(9))
                0: sc = $urandom_range(1) ? 0 : $urandom_range(17, 31);
                1: sc = $urandom_range(5, 16);
                default: sc = $urandom_range(1, 4);
            endcase
            s_eff = (sc == 0) ? 1 : (sc > SCALE_CAP ? SCALE_CAP : sc);
            if (s_eff > 4) begin
                w = s_eff * $urandom_range(1, 2) + $urandom_range(0, 2);
                h = s_eff + $urandom_range(0, 1);
            end else begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 12);
            end
            if ($urandom_range(19) == 0) w = 0;
            if ($urandom_range(19) == 0) h = 0;
            w_eff = (w == 0) ? 1 : w;
            h_eff = (h == 0) ? 1 : h;
            frame = w_eff * h_eff;
            n = frame * $urandom_range(1, 2);
            if ($urandom_range(3) == 0) n += $urandom_range(0, frame - 1);

            scale_data  = blkavg_pkg::CFG_DATA_W'(sc);
            colour_data = blkavg_pkg::CFG_DATA_W'($urandom_range(1));
            if ($urandom_range(3) == 0) begin
                scale_data[blkavg_pkg::CFG_DATA_W-1:blkavg_pkg::SCALE_W] =
                    (blkavg_pkg::CFG_DATA_W - blkavg_pkg::SCALE_W)'($urandom);
                colour_data[blkavg_pkg::CFG_DATA_W-1:1] =
                    (blkavg_pkg::CFG_DATA_W - 1)'($urandom);
            end
            set_geometry(scale_data, blkavg_pkg::CFG_DATA_W'(w), blkavg_pkg::CFG_DATA_W'(h),
                         colour_data);

            if ($urandom_range(15) == 0) begin
                stream_pixels(n / 2);
                // unmapped index leaves registers and position alone
                write_reg(blkavg_pkg::CFG_IDX_W'(blkavg_pkg::CFG_COLOUR) +
                          blkavg_pkg::CFG_IDX_W'($urandom_range(1, 4)),
                          blkavg_pkg::CFG_DATA_W'($urandom));
                stream_pixels(n - n / 2);
            end else begin
                stream_pixels(n);
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.pending_means.size() == 0) begin
            $display("block_average_downscaler regression: pass");
        end else begin
            $display("block_average_downscaler regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
src/blkavg_pkg.sv
src/blkavg_ifs.sv
src/blkavg_ctrl.sv
src/blkavg_lane.sv
src/blkavg_merge.sv
src/block_average_downscaler.sv
src/blkavg_chk.sv
test/tb_top.sv
